FILE: rtl/tdpl_pkg.sv
package tdpl_pkg;

   localparam int SCHED_ENTRIES  = 40;
   localparam int SLOTS_PER_PLAN = 48;
   localparam int DAY_PLANS      = 16;
   localparam int SLOT_DEPTH     = DAY_PLANS * SLOTS_PER_PLAN;

   localparam int SCHED_AW = $clog2(SCHED_ENTRIES);
   localparam int SLOT_AW  = $clog2(SLOT_DEPTH);
   localparam int IDX_W    = 6;
   localparam int MIN_W    = 11;

   localparam int MINUTES_PER_HOUR = 60;
   localparam int MONTH_BITS       = 13;
   localparam int SUNDAY_BIT       = 7;

   typedef enum logic [1:0] {
      CMD_WR_SCHED = 2'd0,
      CMD_WR_SLOT  = 2'd1,
      CMD_QUERY    = 2'd2,
      CMD_CLEAR    = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [4:0]  plan;
      logic [12:0] month_mask;
      logic [31:0] day_mask;
      logic [7:0]  week_mask;
   } sched_entry_type;

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [7:0] action;
   } slot_entry_type;

   typedef struct packed {
      logic clear;
      logic strobe;
   } slot_ctl_type;

   function automatic logic [MIN_W-1:0] minute_of_day(logic [4:0] hour, logic [5:0] minute);
      return MIN_W'(hour) * MIN_W'(MINUTES_PER_HOUR) + MIN_W'(minute);
   endfunction

   function automatic logic sched_match(sched_entry_type e, logic [3:0] month,
                                        logic [4:0] day, logic [2:0] wbit);
      logic month_hit;
      month_hit = (month < 4'(MONTH_BITS)) && e.month_mask[month];
      return (month_hit && e.day_mask[day]) || e.week_mask[wbit];
   endfunction

   function automatic logic [SLOT_AW-1:0] slot_addr(logic [4:0] plan, logic [IDX_W-1:0] idx);
      return SLOT_AW'(plan - 5'd1) * SLOT_AW'(SLOTS_PER_PLAN) + SLOT_AW'(idx);
   endfunction

endpackage

FILE: rtl/tdpl_ram.sv
module tdpl_ram #(
   parameter int Width = 8,
   parameter int Depth = 16,
   localparam int AddrWidth = $clog2(Depth)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrWidth-1:0] wr_addr,
   input  logic [Width-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [AddrWidth-1:0] rd_addr,
   output logic [Width-1:0]     rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/tdpl_slot_sel.sv
module tdpl_slot_sel (
   input  logic                         clock,
   input  logic                         reset,
   input  tdpl_pkg::slot_ctl_type       ctl,
   input  logic [tdpl_pkg::MIN_W-1:0]   cur_min,
   input  tdpl_pkg::slot_entry_type     entry,
   output logic                         hit,
   output logic [7:0]                   sel_action
);

   logic                       have_past_ff, have_past_in;
   logic [tdpl_pkg::MIN_W-1:0] past_start_ff, past_start_in;
   logic [7:0]                 past_action_ff, past_action_in;
   logic                       have_any_ff, have_any_in;
   logic [tdpl_pkg::MIN_W-1:0] latest_start_ff, latest_start_in;
   logic [7:0]                 latest_action_ff, latest_action_in;

   logic [tdpl_pkg::MIN_W-1:0] start;
   logic                       used;
   logic                       past_upd;
   logic                       latest_upd;

   always_comb begin
      start = tdpl_pkg::minute_of_day(entry.hour, entry.minute);
      used  = ctl.strobe && (entry.action != 8'd0);
      hit   = used && (start == cur_min);
      // latest start below the current minute is the smallest gap; strict compare keeps lowest index
      past_upd   = used && (start < cur_min) && (!have_past_ff || start > past_start_ff);
      latest_upd = used && (!have_any_ff || start > latest_start_ff);

      have_past_in     = have_past_ff;
      past_start_in    = past_start_ff;
      past_action_in   = past_action_ff;
      have_any_in      = have_any_ff;
      latest_start_in  = latest_start_ff;
      latest_action_in = latest_action_ff;

      if (ctl.clear) begin
         have_past_in = 1'b0;
         have_any_in  = 1'b0;
      end else begin
         if (past_upd) begin
            have_past_in   = 1'b1;
            past_start_in  = start;
            past_action_in = entry.action;
         end
         if (latest_upd) begin
            have_any_in      = 1'b1;
            latest_start_in  = start;
            latest_action_in = entry.action;
         end
      end

      if (have_past_ff) begin
         sel_action = past_action_ff;
      end else if (have_any_ff) begin
         sel_action = latest_action_ff;
      end else begin
         sel_action = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_past_ff <= 1'b0;
         have_any_ff  <= 1'b0;
      end else begin
         have_past_ff <= have_past_in;
         have_any_ff  <= have_any_in;
      end
      past_start_ff    <= past_start_in;
      past_action_ff   <= past_action_in;
      latest_start_ff  <= latest_start_in;
      latest_action_ff <= latest_action_in;
   end

endmodule

FILE: rtl/time_of_day_plan_lookup.sv
// Channel   Handshake              Payload
// req       req_valid / req_stall  cmd, entry_index, plan_number, masks, time, date
// rsp       rsp_valid / rsp_stall  action_result, plan_result
//
// A query scans the schedule memory one entry per cycle until the first match (up to 40
// reads), then up to 48 slots of that plan one per cycle, stopping on an exact match;
// the response is loaded in the result state, and the next request is taken in idle.
// A write lands in memory on accept. A clear sweeps the slot memory one row per cycle (768).
// After reset the same sweep runs with req_stall high and sends no response.
// A new request is taken while the previous response still waits under rsp_stall.
module time_of_day_plan_lookup (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [5:0]  req_entry_index,
   input  logic [4:0]  req_plan_number,
   input  logic [12:0] req_month_mask,
   input  logic [31:0] req_day_mask,
   input  logic [7:0]  req_week_mask,
   input  logic [4:0]  req_hour,
   input  logic [5:0]  req_minute,
   input  logic [7:0]  req_action_number,
   input  logic [3:0]  req_month,
   input  logic [4:0]  req_day,
   input  logic [2:0]  req_weekday,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_action_result,
   output logic [4:0]  rsp_plan_result
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCHED,
      ST_SLOT,
      ST_RESULT
   } state_type;

   state_type                            state_ff, state_in;
   logic [tdpl_pkg::SLOT_AW-1:0]         clr_addr_ff, clr_addr_in;
   logic                                 clr_rsp_ff, clr_rsp_in;
   logic [tdpl_pkg::MIN_W-1:0]           cur_min_ff, cur_min_in;
   logic [3:0]                           month_ff, month_in;
   logic [4:0]                           day_ff, day_in;
   logic [2:0]                           wbit_ff, wbit_in;
   logic [tdpl_pkg::IDX_W-1:0]           idx_ff, idx_in;
   logic                                 rd_vld_ff, rd_vld_in;
   logic [4:0]                           plan_ff, plan_in;
   logic [tdpl_pkg::SLOT_AW-1:0]         slot_base_ff, slot_base_in;
   logic [7:0]                           action_ff, action_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]                           rsp_action_ff, rsp_action_in;
   logic [4:0]                           rsp_plan_ff, rsp_plan_in;

   logic                                 accept;
   logic                                 plan_ok;
   logic                                 sched_we;
   logic [tdpl_pkg::SCHED_AW-1:0]        sched_waddr;
   tdpl_pkg::sched_entry_type            sched_wdata;
   logic                                 sched_re;
   tdpl_pkg::sched_entry_type            sched_rdata;
   logic                                 slot_we;
   logic [tdpl_pkg::SLOT_AW-1:0]         slot_waddr;
   tdpl_pkg::slot_entry_type             slot_wdata;
   logic                                 slot_re;
   logic [tdpl_pkg::SLOT_AW-1:0]         slot_raddr;
   tdpl_pkg::slot_entry_type             slot_rdata;
   tdpl_pkg::slot_ctl_type               sel_ctl;
   logic                                 sel_hit;
   logic [7:0]                           sel_action;

   function automatic tdpl_pkg::cmd_type cmd_type_of(logic [1:0] code);
      return tdpl_pkg::cmd_type'(code);
   endfunction

   tdpl_ram #(
      .Width ($bits(tdpl_pkg::sched_entry_type)),
      .Depth (tdpl_pkg::SCHED_ENTRIES)
   ) u_sched_ram (
      .clock   (clock),
      .wr_en   (sched_we),
      .wr_addr (sched_waddr),
      .wr_data (sched_wdata),
      .rd_en   (sched_re),
      .rd_addr (idx_ff[tdpl_pkg::SCHED_AW-1:0]),
      .rd_data (sched_rdata)
   );

   tdpl_ram #(
      .Width ($bits(tdpl_pkg::slot_entry_type)),
      .Depth (tdpl_pkg::SLOT_DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata),
      .rd_en   (slot_re),
      .rd_addr (slot_raddr),
      .rd_data (slot_rdata)
   );

   tdpl_slot_sel u_slot_sel (
      .clock      (clock),
      .reset      (reset),
      .ctl        (sel_ctl),
      .cur_min    (cur_min_ff),
      .entry      (slot_rdata),
      .hit        (sel_hit),
      .sel_action (sel_action)
   );

   always_comb begin
      accept  = req_valid && (state_ff == ST_IDLE);
      plan_ok = (req_plan_number != 5'd0) && (req_plan_number <= 5'(tdpl_pkg::DAY_PLANS));

      sched_we    = 1'b0;
      sched_waddr = req_entry_index[tdpl_pkg::SCHED_AW-1:0];
      sched_wdata = '{plan: req_plan_number, month_mask: req_month_mask,
                      day_mask: req_day_mask, week_mask: req_week_mask};
      slot_we     = 1'b0;
      slot_waddr  = tdpl_pkg::slot_addr(req_plan_number, req_entry_index);
      slot_wdata  = '{hour: req_hour, minute: req_minute, action: req_action_number};

      sched_re   = (state_ff == ST_SCHED) && (idx_ff < tdpl_pkg::IDX_W'(tdpl_pkg::SCHED_ENTRIES));
      slot_re    = (state_ff == ST_SLOT) && (idx_ff < tdpl_pkg::IDX_W'(tdpl_pkg::SLOTS_PER_PLAN));
      slot_raddr = slot_base_ff + tdpl_pkg::SLOT_AW'(idx_ff);

      sel_ctl.clear  = 1'b0;
      sel_ctl.strobe = (state_ff == ST_SLOT) && rd_vld_ff;

      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      clr_rsp_in    = clr_rsp_ff;
      cur_min_in    = cur_min_ff;
      month_in      = month_ff;
      day_in        = day_ff;
      wbit_in       = wbit_ff;
      idx_in        = idx_ff;
      rd_vld_in     = rd_vld_ff;
      plan_in       = plan_ff;
      slot_base_in  = slot_base_ff;
      action_in     = action_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_action_in = rsp_action_ff;
      rsp_plan_in   = rsp_plan_ff;

      case (state_ff)
         ST_CLEAR: begin
            sched_we    = clr_addr_ff < tdpl_pkg::SLOT_AW'(tdpl_pkg::SCHED_ENTRIES);
            sched_waddr = clr_addr_ff[tdpl_pkg::SCHED_AW-1:0];
            sched_wdata = '0;
            slot_we     = 1'b1;
            slot_waddr  = clr_addr_ff;
            slot_wdata  = '0;
            clr_addr_in = clr_addr_ff + tdpl_pkg::SLOT_AW'(1);
            if (clr_addr_ff == tdpl_pkg::SLOT_AW'(tdpl_pkg::SLOT_DEPTH - 1)) begin
               clr_addr_in = '0;
               state_in    = clr_rsp_ff ? ST_RESULT : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               plan_in   = 5'd0;
               action_in = 8'd0;
               idx_in    = '0;
               rd_vld_in = 1'b0;
               case (cmd_type_of(req_cmd))
                  tdpl_pkg::CMD_WR_SCHED: begin
                     sched_we = plan_ok &&
                        (req_entry_index < tdpl_pkg::IDX_W'(tdpl_pkg::SCHED_ENTRIES));
                     state_in = ST_RESULT;
                  end
                  tdpl_pkg::CMD_WR_SLOT: begin
                     slot_we  = plan_ok && (req_action_number != 8'd0) &&
                        (req_entry_index < tdpl_pkg::IDX_W'(tdpl_pkg::SLOTS_PER_PLAN));
                     state_in = ST_RESULT;
                  end
                  tdpl_pkg::CMD_QUERY: begin
                     cur_min_in = tdpl_pkg::minute_of_day(req_hour, req_minute);
                     month_in   = req_month;
                     day_in     = req_day;
                     wbit_in    = (req_weekday == 3'd0) ? 3'(tdpl_pkg::SUNDAY_BIT) : req_weekday;
                     state_in   = ST_SCHED;
                  end
                  default: begin
                     clr_addr_in = '0;
                     clr_rsp_in  = 1'b1;
                     state_in    = ST_CLEAR;
                  end
               endcase
            end
         end
         ST_SCHED: begin
            rd_vld_in = sched_re;
            if (sched_re) begin
               idx_in = idx_ff + tdpl_pkg::IDX_W'(1);
            end
            if (rd_vld_ff && tdpl_pkg::sched_match(sched_rdata, month_ff, day_ff, wbit_ff)) begin
               plan_in       = sched_rdata.plan;
               slot_base_in  = tdpl_pkg::slot_addr(sched_rdata.plan, '0);
               sel_ctl.clear = 1'b1;
               idx_in        = '0;
               rd_vld_in     = 1'b0;
               state_in      = ST_SLOT;
            end else if (!rd_vld_ff && !sched_re) begin
               state_in = ST_RESULT;
            end
         end
         ST_SLOT: begin
            rd_vld_in = slot_re;
            if (slot_re) begin
               idx_in = idx_ff + tdpl_pkg::IDX_W'(1);
            end
            // an exact start match ends the scan at once
            if (sel_hit) begin
               action_in = slot_rdata.action;
               state_in  = ST_RESULT;
            end else if (!rd_vld_ff && !slot_re) begin
               action_in = sel_action;
               state_in  = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_action_in = action_ff;
               rsp_plan_in   = plan_ff;
               clr_rsp_in    = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         clr_rsp_ff   <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         clr_rsp_ff   <= clr_rsp_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_min_ff    <= cur_min_in;
      month_ff      <= month_in;
      day_ff        <= day_in;
      wbit_ff       <= wbit_in;
      idx_ff        <= idx_in;
      plan_ff       <= plan_in;
      slot_base_ff  <= slot_base_in;
      action_ff     <= action_in;
      rsp_action_ff <= rsp_action_in;
      rsp_plan_ff   <= rsp_plan_in;
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_action_result = rsp_action_ff;
   assign rsp_plan_result   = rsp_plan_ff;

endmodule
